// ----- src/ataw_pkg.sv -----
`timescale 1ns / 1ps

package ataw_pkg;

    // Address modes held in the mode register.
    localparam logic [1:0] MODE_CHS     = 2'd0;
    localparam logic [1:0] MODE_LBA28   = 2'd1;
    localparam logic [1:0] MODE_LBA48   = 2'd2;
    localparam logic [1:0] MODE_INVALID = 2'd3;

    // Dense taskfile register codes.
    localparam logic [2:0] REG_DRIVE_HEAD   = 3'd0;
    localparam logic [2:0] REG_SECTOR_COUNT = 3'd1;
    localparam logic [2:0] REG_LBA_LOW      = 3'd2;
    localparam logic [2:0] REG_LBA_MID      = 3'd3;
    localparam logic [2:0] REG_LBA_HIGH     = 3'd4;

    // Configuration register indexes (byte address is 8 times the index).
    localparam logic [1:0] CFG_ADDRESS_MODE  = 2'd0;
    localparam logic [1:0] CFG_DRIVE_SELECT  = 2'd1;
    localparam logic [1:0] CFG_DEVICE_CAP    = 2'd2;

    localparam logic [3:0] HEAD_MASK = 4'hF;
    localparam logic [7:0] LBA_BIT   = 8'h40;

    // Index of the final write in each sequence.
    localparam logic [3:0] LAST_STEP_SHORT = 4'd4;
    localparam logic [3:0] LAST_STEP_LBA48 = 4'd8;

    // Reset values of the configuration registers.
    localparam logic [1:0]  MODE_RESET     = MODE_LBA28;
    localparam logic [7:0]  DRIVE_RESET    = 8'hA0;
    localparam logic [47:0] CAPACITY_RESET = 48'd0;

    // Configuration values seen by the datapath.
    typedef struct packed {
        logic [1:0]  address_mode;
        logic [7:0]  drive_select_bits;
        logic [47:0] device_capacity;
    } cfg_t;

    // Request held in the input register, passed to the result stage.
    typedef struct packed {
        logic        valid;
        logic        reject;
        logic [1:0]  mode;
        logic [7:0]  drive;
        logic [47:0] addr;
        logic [15:0] count;
        logic [3:0]  step;
        logic        last;
    } req_t;

endpackage

// ----- src/ataw_cfg_regs.sv -----
`timescale 1ns / 1ps

module ataw_cfg_regs
    import ataw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [1:0]  mode_reg;
    logic [7:0]  drive_reg;
    logic [47:0] capacity_reg;
    logic        wr_en;
    logic [1:0]  reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite & pready;
    assign reg_index = paddr[4:3];

    // Register writes in the access cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_RESET;
            drive_reg    <= DRIVE_RESET;
            capacity_reg <= CAPACITY_RESET;
        end else if (wr_en) begin
            case (reg_index)
                CFG_ADDRESS_MODE: mode_reg     <= pwdata[1:0];
                CFG_DRIVE_SELECT: drive_reg    <= pwdata[7:0];
                CFG_DEVICE_CAP:   capacity_reg <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    // Read back.
    always_comb begin
        case (reg_index)
            CFG_ADDRESS_MODE: prdata = {62'd0, mode_reg};
            CFG_DRIVE_SELECT: prdata = {56'd0, drive_reg};
            CFG_DEVICE_CAP:   prdata = {16'd0, capacity_reg};
            default:          prdata = 64'd0;
        endcase
    end

    assign cfg.address_mode      = mode_reg;
    assign cfg.drive_select_bits = drive_reg;
    assign cfg.device_capacity   = capacity_reg;

endmodule

// ----- src/ataw_req_stage.sv -----
`timescale 1ns / 1ps

module ataw_req_stage
    import ataw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] start_address,
    input  logic [15:0] sector_count,
    input  logic        advance,
    output req_t        req
);

    logic        valid_reg;
    logic        valid_next;
    logic [3:0]  step_reg;
    logic [3:0]  step_next;
    logic        reject_reg;
    logic [1:0]  mode_reg;
    logic [7:0]  drive_reg;
    logic [47:0] addr_reg;
    logic [15:0] count_reg;
    logic        last;
    logic        take;
    logic        reject_in;

    // The last write of the sequence frees the register for the next request.
    assign last     = reject_reg ||
                      (step_reg == ((mode_reg == MODE_LBA48) ? LAST_STEP_LBA48
                                                             : LAST_STEP_SHORT));
    assign s_tready = !valid_reg || (advance && last);
    assign take     = s_tvalid && s_tready;

    // Rejection check is done once, when the request is taken in.
    assign reject_in = (sector_count == 16'd0) ||
                       ({32'd0, sector_count} > cfg.device_capacity) ||
                       (cfg.address_mode == MODE_INVALID);

    always_comb begin
        valid_next = valid_reg;
        step_next  = step_reg;
        if (advance) begin
            if (last) begin
                valid_next = 1'b0;
                step_next  = 4'd0;
            end else begin
                step_next = step_reg + 4'd1;
            end
        end
        if (take) begin
            valid_next = 1'b1;
            step_next  = 4'd0;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            step_reg  <= 4'd0;
        end else begin
            valid_reg <= valid_next;
            step_reg  <= step_next;
        end
    end

    // Request payload, with the configuration in force when it arrived.
    always_ff @(posedge aclk) begin
        if (take) begin
            reject_reg <= reject_in;
            mode_reg   <= cfg.address_mode;
            drive_reg  <= cfg.drive_select_bits;
            addr_reg   <= start_address;
            count_reg  <= sector_count;
        end
    end

    assign req.valid  = valid_reg;
    assign req.reject = reject_reg;
    assign req.mode   = mode_reg;
    assign req.drive  = drive_reg;
    assign req.addr   = addr_reg;
    assign req.count  = count_reg;
    assign req.step   = step_reg;
    assign req.last   = last;

endmodule

// ----- src/ataw_out_stage.sv -----
`timescale 1ns / 1ps

module ataw_out_stage
    import ataw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  req_t        req,
    output logic        advance,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        write_valid,
    output logic [2:0]  register_code,
    output logic [15:0] write_data,
    output logic        accepted,
    output logic        last_write
);

    logic        m_valid_reg;
    logic        write_valid_reg;
    logic [2:0]  code_reg;
    logic [15:0] data_reg;
    logic        accepted_reg;
    logic        last_reg;
    logic        load;
    logic [2:0]  code_c;
    logic [15:0] data_c;
    logic [7:0]  dh_byte;

    assign load    = !m_valid_reg || m_tready;
    assign advance = req.valid && load;

    // Drive/head byte for the current mode.
    always_comb begin
        case (req.mode)
            MODE_CHS:   dh_byte = req.drive | {4'd0, req.addr[27:24] & HEAD_MASK};
            MODE_LBA28: dh_byte = req.drive | LBA_BIT |
                                  {4'd0, req.addr[27:24] & HEAD_MASK};
            default:    dh_byte = req.drive | LBA_BIT;
        endcase
    end

    // Register code and data for the current step.
    always_comb begin
        code_c = REG_DRIVE_HEAD;
        data_c = 16'd0;
        if (!req.reject) begin
            if (req.mode == MODE_LBA48) begin
                case (req.step)
                    4'd0: begin code_c = REG_DRIVE_HEAD;   data_c = {8'd0, dh_byte}; end
                    4'd1: begin code_c = REG_SECTOR_COUNT; data_c = {8'd0, req.count[15:8]}; end
                    4'd2: begin code_c = REG_LBA_LOW;      data_c = {8'd0, req.addr[31:24]}; end
                    4'd3: begin code_c = REG_LBA_MID;      data_c = {8'd0, req.addr[39:32]}; end
                    4'd4: begin code_c = REG_LBA_HIGH;     data_c = {8'd0, req.addr[47:40]}; end
                    4'd5: begin code_c = REG_SECTOR_COUNT; data_c = {8'd0, req.count[7:0]}; end
                    4'd6: begin code_c = REG_LBA_LOW;      data_c = {8'd0, req.addr[7:0]}; end
                    4'd7: begin code_c = REG_LBA_MID;      data_c = {8'd0, req.addr[15:8]}; end
                    default: begin code_c = REG_LBA_HIGH;  data_c = {8'd0, req.addr[23:16]}; end
                endcase
            end else begin
                case (req.step)
                    4'd0: begin code_c = REG_DRIVE_HEAD; data_c = {8'd0, dh_byte}; end
                    4'd1: begin
                        code_c = REG_SECTOR_COUNT;
                        // LBA28 keeps only the low byte of the count.
                        data_c = (req.mode == MODE_LBA28) ? {8'd0, req.count[7:0]}
                                                          : req.count;
                    end
                    4'd2: begin code_c = REG_LBA_LOW;   data_c = {8'd0, req.addr[7:0]}; end
                    4'd3: begin code_c = REG_LBA_MID;   data_c = {8'd0, req.addr[15:8]}; end
                    default: begin code_c = REG_LBA_HIGH; data_c = {8'd0, req.addr[23:16]}; end
                endcase
            end
        end
    end

    // Output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= req.valid;
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (advance) begin
            write_valid_reg <= !req.reject;
            code_reg        <= code_c;
            data_reg        <= data_c;
            accepted_reg    <= !req.reject;
            last_reg        <= req.last;
        end
    end

    assign m_tvalid      = m_valid_reg;
    assign write_valid   = write_valid_reg;
    assign register_code = code_reg;
    assign write_data    = data_reg;
    assign accepted      = accepted_reg;
    assign last_write    = last_reg;

endmodule

// ----- src/ata_taskfile_write_sequencer_unit.sv -----
`timescale 1ns / 1ps
// The input register holds the request; m_ shows each write from the output register.
// One write per cycle while m_tready is high; a request gives one beat if rejected,
// 5 writes in CHS or LBA28 mode and 9 in LBA48 mode, set by the write step counter.
// The next request is taken in the cycle its predecessor's last write leaves the counter.
// Reset (aresetn, synchronous, active low) empties both stages and loads the registers
// with mode LBA28, drive byte 0xA0 and capacity 0.

module ata_taskfile_write_sequencer_unit
    import ataw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [47:0] start_address, [63:48] sector_count
    // Write channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [2:0] register_code, [18:3] write_data, [23:19] zero
    output logic [1:0]  m_tuser,   // [0] write_valid, [1] accepted
    output logic        m_tlast,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    cfg_t        cfg;
    req_t        req;
    logic        advance;
    logic        write_valid;
    logic [2:0]  register_code;
    logic [15:0] write_data;
    logic        accepted;

    ataw_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ataw_req_stage u_req (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .start_address (s_tdata[47:0]),
        .sector_count  (s_tdata[63:48]),
        .advance       (advance),
        .req           (req)
    );

    ataw_out_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .req           (req),
        .advance       (advance),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .write_valid   (write_valid),
        .register_code (register_code),
        .write_data    (write_data),
        .accepted      (accepted),
        .last_write    (m_tlast)
    );

    assign m_tdata = {5'd0, write_data, register_code};
    assign m_tuser = {accepted, write_valid};

endmodule
